>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers. They expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed: invariant violated");
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rstn, cond)
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/fcache_pkg.sv
// ----------------------------------------------------------------------------
// FIFO cache package
// Shared widths, constants and control structs of the FIFO tag cache.
// ----------------------------------------------------------------------------
package fcache_pkg;

    localparam int KEY_BITS      = 32;
    localparam int COUNT_BITS    = 16;
    localparam int CAP_BITS      = 4;
    localparam int OCC_BITS      = 4;
    localparam int DEPTH_DEFAULT = 8;
    // Widest slot index over the supported depth range.
    localparam int SLOT_MAX_BITS = 6;

    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(3);

    typedef struct packed {
        logic                     hit;
        logic [SLOT_MAX_BITS-1:0] slot;
    } tag_match_t;

    typedef struct packed {
        logic                     full;
        logic [SLOT_MAX_BITS-1:0] slot;
        logic [OCC_BITS-1:0]      occupancy;
    } ring_ctl_t;

    function automatic int slot_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

>>> rtl/core/fcache_tag_match.sv
// ----------------------------------------------------------------------------
// FIFO cache tag match
// Compares the key against every valid tag in parallel and encodes the hit.
// ----------------------------------------------------------------------------
module fcache_tag_match #(
    parameter int DEPTH = fcache_pkg::DEPTH_DEFAULT
) (
    input  logic [fcache_pkg::KEY_BITS-1:0] key,
    input  logic [fcache_pkg::KEY_BITS-1:0] tags [DEPTH],
    input  logic [DEPTH-1:0]                valid,
    output fcache_pkg::tag_match_t          match
);
    import fcache_pkg::*;

    // Keys in the cache are unique, so at most one entry matches and the
    // slot number can be built by OR-ing the indexes of matching entries.
    always_comb begin
        match = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (valid[i] && (tags[i] == key)) begin
                match.hit  = 1'b1;
                match.slot = match.slot | SLOT_MAX_BITS'(i);
            end
        end
    end

endmodule

>>> rtl/core/fcache_ring_ctrl.sv
// ----------------------------------------------------------------------------
// FIFO cache ring control
// Holds capacity, oldest slot and fill count, and picks the slot to fill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcache_ring_ctrl #(
    parameter int DEPTH = fcache_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [fcache_pkg::CAP_BITS-1:0] cfg_data,
    input  logic                            item_we,
    input  logic                            miss,
    output fcache_pkg::ring_ctl_t           ctl
);
    import fcache_pkg::*;

    localparam int SLOT_W = slot_bits(DEPTH);
    localparam int AW     = ((SLOT_W > OCC_BITS) ? SLOT_W : OCC_BITS) + 1;

    logic [CAP_BITS-1:0] capacity_reg, capacity_next;
    logic [SLOT_W-1:0]   oldest_reg, oldest_next;
    logic [OCC_BITS-1:0] fill_reg, fill_next;

    logic [CAP_BITS-1:0] cap_eff;
    logic                full;
    logic [AW-1:0]       free_sum;
    logic [AW-1:0]       free_slot;
    logic [AW-1:0]       oldest_inc;

    // A capacity of zero acts as one; any capacity above the built depth acts as the depth.
    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = CAP_BITS'(1);
        end else if (int'(capacity_reg) > DEPTH) begin
            cap_eff = CAP_BITS'(DEPTH);
        end else begin
            cap_eff = capacity_reg;
        end
    end

    assign full = AW'(fill_reg) >= AW'(cap_eff);

    // Oldest slot and fill count are both below the capacity here, so one
    // conditional subtract wraps the free slot into the ring.
    assign free_sum   = AW'(oldest_reg) + AW'(fill_reg);
    assign free_slot  = (free_sum >= AW'(cap_eff)) ? (free_sum - AW'(cap_eff)) : free_sum;
    assign oldest_inc = ((AW'(oldest_reg) + AW'(1)) == AW'(cap_eff)) ?
                        '0 : (AW'(oldest_reg) + AW'(1));

    always_comb begin
        capacity_next = capacity_reg;
        oldest_next   = oldest_reg;
        fill_next     = fill_reg;
        if (cfg_we) begin
            capacity_next = cfg_data;
            oldest_next   = '0;
            fill_next     = '0;
        end else if (item_we && miss) begin
            if (full) begin
                oldest_next = oldest_inc[SLOT_W-1:0];
            end else begin
                fill_next = fill_reg + OCC_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            oldest_reg   <= '0;
            fill_reg     <= '0;
        end else begin
            capacity_reg <= capacity_next;
            oldest_reg   <= oldest_next;
            fill_reg     <= fill_next;
        end
    end

    always_comb begin
        ctl.full      = full;
        ctl.slot      = SLOT_MAX_BITS'(full ? oldest_reg : free_slot[SLOT_W-1:0]);
        ctl.occupancy = (miss && !full) ? (fill_reg + OCC_BITS'(1)) : fill_reg;
    end

    `ASSERT_ALWAYS(a_fill_within_cap, aclk, aresetn, AW'(fill_reg) <= AW'(cap_eff))
    `ASSERT_ALWAYS(a_oldest_within_cap, aclk, aresetn, AW'(oldest_reg) < AW'(cap_eff))
    `ASSERT_NEXT(a_cfg_empties_ring, aclk, aresetn, cfg_we, (fill_reg == '0) && (oldest_reg == '0))

endmodule

>>> rtl/core/fifo_cache_with_hit_counts_unit.sv
// ----------------------------------------------------------------------------
// FIFO cache with hit counts
// Fully associative tag cache with first-in-first-out replacement.
//
// Each word on the s_ channel carries one key. The key is compared against
// all valid entries at once. On a hit the entry's access count goes up and
// saturates; on a miss the key is written into the next ring slot with a
// count of one, evicting and reporting the oldest entry when the ring is full.
// One result word per key leaves on the m_ channel in the cycle after the key
// is accepted; while the receiver does not stall, a new key can be taken in
// every cycle: one word per cycle, set by the single compare-and-update pass.
// The result register lets the next key in while the current result is
// taken; when the receiver stalls, s_ready drops until the result is taken.
// The cfg channel writes the capacity (ring slots in use) and flushes the
// cache; it is always ready, and the user must see it is written only while
// idle (the block does not enforce this). After reset: empty, capacity three.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_cache_with_hit_counts_unit #(
    parameter int DEPTH = fcache_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Key input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fcache_pkg::KEY_BITS-1:0]   s_key,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [fcache_pkg::COUNT_BITS-1:0] m_access_count,
    output logic                              m_evicted,
    output logic [fcache_pkg::KEY_BITS-1:0]   m_evicted_key,
    output logic [fcache_pkg::OCC_BITS-1:0]   m_occupancy,
    // Capacity write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fcache_pkg::CAP_BITS-1:0]   cfg_data
);
    import fcache_pkg::*;

    localparam int SLOT_W = slot_bits(DEPTH);

    // Entry storage. Tags and counts are only read from valid entries, so
    // only the valid bits are cleared by reset and by a capacity write.
    logic [KEY_BITS-1:0]   tag_reg   [DEPTH];
    logic [COUNT_BITS-1:0] count_reg [DEPTH];
    logic [DEPTH-1:0]      valid_reg;

    // Result register.
    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [COUNT_BITS-1:0] m_access_count_reg;
    logic                  m_evicted_reg;
    logic [KEY_BITS-1:0]   m_evicted_key_reg;
    logic [OCC_BITS-1:0]   m_occupancy_reg;

    logic                  s_accept;
    logic                  cfg_we;
    logic                  item_we;
    tag_match_t            match;
    ring_ctl_t             ring;
    logic [SLOT_W-1:0]     hit_slot;
    logic [SLOT_W-1:0]     ins_slot;
    logic [COUNT_BITS-1:0] hit_count;
    logic [COUNT_BITS-1:0] bumped_count;
    logic                  evict;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    // A capacity write takes precedence over the state update of a key.
    assign item_we   = s_accept && !cfg_we;

    fcache_tag_match #(
        .DEPTH (DEPTH)
    ) u_tag_match (
        .key   (s_key),
        .tags  (tag_reg),
        .valid (valid_reg),
        .match (match)
    );

    fcache_ring_ctrl #(
        .DEPTH (DEPTH)
    ) u_ring_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item_we  (item_we),
        .miss     (!match.hit),
        .ctl      (ring)
    );

    assign hit_slot     = match.slot[SLOT_W-1:0];
    assign ins_slot     = ring.slot[SLOT_W-1:0];
    assign hit_count    = count_reg[hit_slot];
    // The count saturates at its all-ones maximum.
    assign bumped_count = (hit_count == '1) ? hit_count : (hit_count + COUNT_BITS'(1));
    assign evict        = !match.hit && ring.full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cfg_we) begin
            valid_reg <= '0;
        end else if (item_we && !match.hit) begin
            valid_reg[ins_slot] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_we) begin
            if (match.hit) begin
                count_reg[hit_slot] <= bumped_count;
            end else begin
                tag_reg[ins_slot]   <= s_key;
                count_reg[ins_slot] <= COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_hit_reg          <= match.hit;
            m_access_count_reg <= match.hit ? bumped_count : COUNT_BITS'(1);
            m_evicted_reg      <= evict;
            m_evicted_key_reg  <= evict ? tag_reg[ins_slot] : '0;
            m_occupancy_reg    <= ring.occupancy;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_access_count = m_access_count_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_evicted_key  = m_evicted_key_reg;
    assign m_occupancy    = m_occupancy_reg;

    `ASSERT_NEXT(a_result_follows_key, aclk, aresetn, s_accept, m_valid_reg)
    `ASSERT_IMPLY(a_miss_count_one, aclk, aresetn, m_valid_reg && !m_hit_reg, m_access_count_reg == COUNT_BITS'(1))
    `ASSERT_IMPLY(a_evict_only_on_miss, aclk, aresetn, m_valid_reg && m_evicted_reg, !m_hit_reg)

endmodule
